>>> design/cbmf_pkg.sv
// Shared constants and codes for the clipped box mean filter.
package cbmf_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_MAX_RADIUS = 8;
  localparam int DEF_PIXEL_BITS = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int MEAN_W     = 24;
  localparam int IN_PIX_W   = 16;
  localparam int RADIUS_W   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  localparam logic [MEAN_W-1:0] MEAN_MAX = 24'hFFFFFF;

  localparam logic [CFG_DATA_W-1:0] RST_WIDTH  = 10'd512;
  localparam logic [CFG_DATA_W-1:0] RST_HEIGHT = 10'd512;
  localparam logic [RADIUS_W-1:0]   RST_RADIUS = 4'd8;

endpackage

>>> design/cbmf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module cbmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/cbmf_scan.sv
// Window scanner that reads the line buffer one pixel a cycle and sums the window.
module cbmf_scan #(
  parameter int MAX_WIDTH  = 512,
  parameter int RING_ROWS  = 25,
  parameter int PIXEL_BITS = 16,
  parameter int SUM_W      = 25,
  parameter int AW         = 14,
  parameter int SLOT_W     = 5,
  parameter int XW         = 10,
  parameter int RW         = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [SLOT_W-1:0]     slot_i,
  input  logic [XW-1:0]         x0_i,
  input  logic [RW-1:0]         rows_i,
  input  logic [RW-1:0]         cols_i,
  output logic [AW-1:0]         raddr_o,
  input  logic [PIXEL_BITS-1:0] rdata_i,
  output logic                  done_o,
  output logic [SUM_W-1:0]      sum_o
);

  localparam int RING_SPAN = RING_ROWS * MAX_WIDTH;

  logic              busy_q, busy_d, pend_q, pend_d, last_q, last_d, done_q, done_d;
  logic [AW-1:0]     base_q, base_d;
  logic [XW-1:0]     x_q, x_d, x0_q, x0_d;
  logic [RW-1:0]     cols_q, cols_d, col_left_q, col_left_d, row_left_q, row_left_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [AW:0]       next_base;

  always_comb begin
    busy_d     = busy_q;
    base_d     = base_q;
    x_d        = x_q;
    x0_d       = x0_q;
    cols_d     = cols_q;
    col_left_d = col_left_q;
    row_left_d = row_left_q;
    sum_d      = sum_q;
    pend_d     = busy_q;
    last_d     = busy_q && (col_left_q == '0) && (row_left_q == '0);
    done_d     = pend_q && last_q;
    next_base  = (AW+1)'(base_q) + (AW+1)'(MAX_WIDTH);
    if (next_base >= (AW+1)'(RING_SPAN)) begin
      next_base = next_base - (AW+1)'(RING_SPAN);
    end
    if (pend_q) begin
      sum_d = sum_q + SUM_W'(rdata_i);
    end
    if (start_i) begin
      busy_d     = 1'b1;
      base_d     = AW'(int'(slot_i) * MAX_WIDTH);
      x_d        = x0_i;
      x0_d       = x0_i;
      cols_d     = cols_i;
      col_left_d = cols_i - RW'(1);
      row_left_d = rows_i - RW'(1);
      sum_d      = '0;
    end else if (busy_q) begin
      if (col_left_q == '0) begin
        if (row_left_q == '0) begin
          busy_d = 1'b0;
        end else begin
          row_left_d = row_left_q - RW'(1);
          col_left_d = cols_q - RW'(1);
          x_d        = x0_q;
          base_d     = next_base[AW-1:0];
        end
      end else begin
        col_left_d = col_left_q - RW'(1);
        x_d        = x_q + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      last_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pend_q <= pend_d;
      last_q <= last_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    x_q        <= x_d;
    x0_q       <= x0_d;
    cols_q     <= cols_d;
    col_left_q <= col_left_d;
    row_left_q <= row_left_d;
    sum_q      <= sum_d;
  end

  assign raddr_o = base_q + AW'(x_q);
  assign done_o  = done_q;
  assign sum_o   = sum_q;

endmodule

>>> design/cbmf_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module cbmf_div #(
  parameter int NW = 33,
  parameter int DW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] q_q, q_d;
  logic [DW-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [DW:0]   rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    q_d    = q_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    rem_sh = {rem_q, q_q[NW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NW);
      q_d    = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = DW'(rem_sh - {1'b0, dvs_q});
        q_d   = {q_q[NW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DW-1:0];
        q_d   = {q_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    q_q   <= q_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

>>> design/clipped_box_mean_filter_top.sv
// Top level of the clipped box mean filter.
// Pixels enter in raster order and each result is the mean of the clipped (2r+1)-square
// window around one position, as floor(sum*256/count), lagging the input by r*W+r pixels;
// flush requests after the last pixel push out the trailing results. Recent rows live in
// a ring of 3*MAX_RADIUS+1 rows in one memory. A request that yields no result leaves the
// block idle and ready for the next request. A request that yields a result holds off
// further requests until its mean is in the output register: the window, up to 17x17 at
// the defaults, is summed one pixel per cycle over the memory's single read port, then
// divided one bit per cycle.
// A result waits in an output register; the next request is taken while it waits.
module clipped_box_mean_filter_top #(
  parameter int MAX_WIDTH  = cbmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cbmf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = cbmf_pkg::DEF_MAX_RADIUS,
  parameter int PIXEL_BITS = cbmf_pkg::DEF_PIXEL_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [cbmf_pkg::IN_PIX_W-1:0]     pixel_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cbmf_pkg::MEAN_W-1:0]       mean_value_o,
  output logic                              frame_last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cbmf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cbmf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import cbmf_pkg::*;

  localparam int RING_ROWS = 3 * MAX_RADIUS + 1;
  localparam int SLOT_W    = $clog2(RING_ROWS);
  localparam int DEPTH     = RING_ROWS * MAX_WIDTH;
  localparam int AW        = $clog2(DEPTH);
  localparam int XW        = $clog2(MAX_WIDTH + 1);
  localparam int YW        = $clog2(MAX_HEIGHT + 1);
  localparam int RDW       = $clog2(MAX_RADIUS + 1);
  localparam int RW        = $clog2(2 * MAX_RADIUS + 2);
  localparam int CNT_MAX   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CNTW      = $clog2(CNT_MAX + 1);
  localparam int SUM_W     = PIXEL_BITS + CNTW;
  localparam int NW        = SUM_W + 8;
  localparam int LAGW      = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
  localparam int QXW       = NW + MEAN_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_PUT  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CFG_DATA_W-1:0] width_q, width_d, height_q, height_d;
  logic [RADIUS_W-1:0]   radius_q, radius_d;
  logic [XW-1:0]         icol_q, icol_d, ocol_q, ocol_d;
  logic [YW-1:0]         irow_q, irow_d, orow_q, orow_d;
  logic [SLOT_W-1:0]     islot_q, islot_d, oslot_q, oslot_d;
  logic [LAGW-1:0]       diff_q, diff_d;
  logic [CNTW-1:0]       count_q, count_d;
  logic                  flast_q, flast_d, last_q, last_d;
  logic                  out_valid_q, out_valid_d;
  logic [MEAN_W-1:0]     mean_q, mean_d;

  logic [XW-1:0]         w_eff;
  logic [YW-1:0]         h_eff;
  logic [RDW-1:0]        r_eff;
  logic [LAGW-1:0]       lag;
  logic                  accept, input_done, store, emit, final_pos;
  logic                  ram_we;
  logic [AW-1:0]         waddr, raddr;
  logic [PIXEL_BITS-1:0] wdata, rdata;
  logic                  scan_start, scan_done, div_done;
  logic [SLOT_W-1:0]     scan_slot;
  logic [XW-1:0]         scan_x0;
  logic [RW-1:0]         scan_rows, scan_cols;
  logic [SUM_W-1:0]      win_sum;
  logic [NW-1:0]         quot;
  logic [QXW-1:0]        quot_ext;
  int                    y0, y1, x0, x1, dy, slot0, nrows, ncols;

  always_comb begin
    if (width_q == '0) begin
      w_eff = XW'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = XW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = YW'(1);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      h_eff = YW'(MAX_HEIGHT);
    end else begin
      h_eff = YW'(height_q);
    end
    if (int'(radius_q) > MAX_RADIUS) begin
      r_eff = RDW'(MAX_RADIUS);
    end else begin
      r_eff = RDW'(radius_q);
    end
    lag = LAGW'(r_eff) * LAGW'(w_eff) + LAGW'(r_eff);
  end

  always_comb begin
    y0 = (int'(orow_q) >= int'(r_eff)) ? int'(orow_q) - int'(r_eff) : 0;
    y1 = (int'(orow_q) + int'(r_eff) < int'(h_eff)) ? int'(orow_q) + int'(r_eff)
                                                     : int'(h_eff) - 1;
    x0 = (int'(ocol_q) >= int'(r_eff)) ? int'(ocol_q) - int'(r_eff) : 0;
    x1 = (int'(ocol_q) + int'(r_eff) < int'(w_eff)) ? int'(ocol_q) + int'(r_eff)
                                                     : int'(w_eff) - 1;
    nrows = y1 - y0 + 1;
    ncols = x1 - x0 + 1;
    dy    = int'(orow_q) - y0;
    slot0 = int'(oslot_q) - dy;
    if (slot0 < 0) begin
      slot0 = slot0 + RING_ROWS;
    end
    scan_slot = SLOT_W'(slot0);
    scan_x0   = XW'(x0);
    scan_rows = RW'(nrows);
    scan_cols = RW'(ncols);
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign input_done  = (irow_q >= h_eff);
  assign final_pos   = (orow_q == h_eff - YW'(1)) && (ocol_q == w_eff - XW'(1));
  assign wdata       = PIXEL_BITS'(pixel_i);
  assign waddr       = AW'(int'(islot_q) * MAX_WIDTH + int'(icol_q));
  assign ram_we      = store;
  assign quot_ext    = QXW'(quot);

  always_comb begin
    store = 1'b0;
    emit  = 1'b0;
    if (accept) begin
      if (mode_i == MODE_FLUSH || input_done) begin
        emit = input_done;
      end else begin
        store = 1'b1;
        emit  = (diff_q >= lag);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    width_d     = width_q;
    height_d    = height_q;
    radius_d    = radius_q;
    icol_d      = icol_q;
    irow_d      = irow_q;
    islot_d     = islot_q;
    ocol_d      = ocol_q;
    orow_d      = orow_q;
    oslot_d     = oslot_q;
    diff_d      = diff_q + LAGW'(store) - LAGW'(emit);
    count_d     = count_q;
    last_d      = last_q;
    flast_d     = flast_q;
    mean_d      = mean_q;
    out_valid_d = out_valid_q && !out_ready_i;
    scan_start  = 1'b0;

    if (store) begin
      if (icol_q + XW'(1) >= w_eff) begin
        icol_d = '0;
        irow_d = irow_q + YW'(1);
        islot_d = (int'(islot_q) == RING_ROWS - 1) ? '0 : islot_q + SLOT_W'(1);
      end else begin
        icol_d = icol_q + XW'(1);
      end
    end

    if (emit) begin
      scan_start = 1'b1;
      state_d    = ST_SCAN;
      count_d    = CNTW'(nrows * ncols);
      last_d     = final_pos;
      if (final_pos) begin
        icol_d  = '0;
        irow_d  = '0;
        islot_d = '0;
        ocol_d  = '0;
        orow_d  = '0;
        oslot_d = '0;
        diff_d  = '0;
      end else if (ocol_q + XW'(1) >= w_eff) begin
        ocol_d  = '0;
        orow_d  = orow_q + YW'(1);
        oslot_d = (int'(oslot_q) == RING_ROWS - 1) ? '0 : oslot_q + SLOT_W'(1);
      end else begin
        ocol_d = ocol_q + XW'(1);
      end
    end

    unique case (state_q)
      ST_IDLE: begin
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          flast_d     = last_q;
          mean_d      = (quot_ext > QXW'(MEAN_MAX)) ? MEAN_MAX : quot_ext[MEAN_W-1:0];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_valid_i && cfg_ready_o &&
        (cfg_index_i == CFG_WIDTH || cfg_index_i == CFG_HEIGHT ||
         cfg_index_i == CFG_RADIUS)) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  width_d  = cfg_data_i;
        CFG_HEIGHT: height_d = cfg_data_i;
        default:    radius_d = cfg_data_i[RADIUS_W-1:0];
      endcase
      icol_d  = '0;
      irow_d  = '0;
      islot_d = '0;
      ocol_d  = '0;
      orow_d  = '0;
      oslot_d = '0;
      diff_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= RST_WIDTH;
      height_q    <= RST_HEIGHT;
      radius_q    <= RST_RADIUS;
      icol_q      <= '0;
      irow_q      <= '0;
      islot_q     <= '0;
      ocol_q      <= '0;
      orow_q      <= '0;
      oslot_q     <= '0;
      diff_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      width_q     <= width_d;
      height_q    <= height_d;
      radius_q    <= radius_d;
      icol_q      <= icol_d;
      irow_q      <= irow_d;
      islot_q     <= islot_d;
      ocol_q      <= ocol_d;
      orow_q      <= orow_d;
      oslot_q     <= oslot_d;
      diff_q      <= diff_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    last_q  <= last_d;
    flast_q <= flast_d;
    mean_q  <= mean_d;
  end

  cbmf_ram #(
    .WIDTH(PIXEL_BITS),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  cbmf_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .RING_ROWS (RING_ROWS),
    .PIXEL_BITS(PIXEL_BITS),
    .SUM_W     (SUM_W),
    .AW        (AW),
    .SLOT_W    (SLOT_W),
    .XW        (XW),
    .RW        (RW)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(scan_start),
    .slot_i (scan_slot),
    .x0_i   (scan_x0),
    .rows_i (scan_rows),
    .cols_i (scan_cols),
    .raddr_o(raddr),
    .rdata_i(rdata),
    .done_o (scan_done),
    .sum_o  (win_sum)
  );

  cbmf_div #(
    .NW(NW),
    .DW(CNTW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (scan_done),
    .dividend_i({win_sum, 8'd0}),
    .divisor_i (count_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign out_valid_o  = out_valid_q;
  assign mean_value_o = mean_q;
  assign frame_last_o = flast_q;

endmodule

>>> dv/cbmf_checker.sv
// Watches the filter channels, predicts each window mean and compares it with the block.
`timescale 1ns / 100ps
module cbmf_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic                            mode_i,
  input  logic [cbmf_pkg::IN_PIX_W-1:0]   pixel_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [cbmf_pkg::MEAN_W-1:0]     mean_value_i,
  input  logic                            frame_last_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [cbmf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cbmf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              errors_o,
  output int                              pending_o
);
  import cbmf_pkg::*;

  localparam int RING = 3 * DEF_MAX_RADIUS + 1;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic              last;
  } mean_t;

  mean_t mean_queue[$];
  logic [IN_PIX_W-1:0] pix_ring [RING*DEF_MAX_WIDTH];
  int width_reg, height_reg, radius_reg;
  int in_row, in_col, out_row, out_col;

  assign pending_o = mean_queue.size();

  function automatic int eff_w();
    if (width_reg == 0) return 1;
    return (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
  endfunction

  function automatic int eff_h();
    if (height_reg == 0) return 1;
    return (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : height_reg;
  endfunction

  function automatic int eff_r();
    return (radius_reg > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : radius_reg;
  endfunction

  task automatic push_window_mean();
    int w, h, r, y0, y1, x0, x1;
    longint sum, cnt, mean;
    mean_t e;
    w = eff_w();
    h = eff_h();
    r = eff_r();
    y0 = (out_row >= r) ? out_row - r : 0;
    y1 = (out_row + r < h) ? out_row + r : h - 1;
    x0 = (out_col >= r) ? out_col - r : 0;
    x1 = (out_col + r < w) ? out_col + r : w - 1;
    sum = 0;
    for (int y = y0; y <= y1; y++) begin
      for (int x = x0; x <= x1; x++) begin
        sum += pix_ring[(y % RING) * DEF_MAX_WIDTH + x];
      end
    end
    cnt = longint'(y1 - y0 + 1) * longint'(x1 - x0 + 1);
    mean = (sum << 8) / cnt;
    if (mean > longint'(MEAN_MAX)) mean = longint'(MEAN_MAX);
    e.mean = mean[MEAN_W-1:0];
    e.last = (out_row == h - 1) && (out_col == w - 1);
    mean_queue.push_back(e);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) begin
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
      end
    end
  endtask

  task automatic take_request(input logic m, input logic [IN_PIX_W-1:0] p);
    int w, r, received, out_idx;
    w = eff_w();
    r = eff_r();
    if (in_row >= eff_h()) begin
      push_window_mean();
      return;
    end
    if (m == MODE_FLUSH) return;
    pix_ring[(in_row % RING) * DEF_MAX_WIDTH + in_col] = p;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    received = in_row * w + in_col;
    out_idx = out_row * w + out_col;
    if (received > out_idx + r * w + r) push_window_mean();
  endtask

  initial begin
    errors_o = 0;
    width_reg = RST_WIDTH;
    height_reg = RST_HEIGHT;
    radius_reg = RST_RADIUS;
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
    foreach (pix_ring[i]) pix_ring[i] = '0;
  end

  always @(posedge clk_i) begin
    mean_t e;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_WIDTH: width_reg = cfg_data_i;
          CFG_HEIGHT: height_reg = cfg_data_i;
          CFG_RADIUS: radius_reg = cfg_data_i[RADIUS_W-1:0];
          default: ;
        endcase
        if (cfg_index_i inside {CFG_WIDTH, CFG_HEIGHT, CFG_RADIUS}) begin
          in_row = 0;
          in_col = 0;
          out_row = 0;
          out_col = 0;
        end
      end
      if (in_valid_i && in_ready_i) take_request(mode_i, pixel_i);
      if (out_valid_i && out_ready_i) begin
        if (mean_queue.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual mean %h last %b",
                   $time, mean_value_i, frame_last_i);
          errors_o++;
        end else begin
          e = mean_queue.pop_front();
          if (mean_value_i !== e.mean) begin
            $display("%0t: mean_value mismatch: expected %h, actual %h",
                     $time, e.mean, mean_value_i);
            errors_o++;
          end
          if (frame_last_i !== e.last) begin
            $display("%0t: frame_last mismatch: expected %b, actual %b",
                     $time, e.last, frame_last_i);
            errors_o++;
          end
        end
      end
    end
  end
endmodule

>>> dv/tb_clipped_box_mean_filter_top.sv
// Stimulus and verdict for the clipped box mean filter testbench.
`timescale 1ns / 100ps
module tb_clipped_box_mean_filter_top;
  import cbmf_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic mode_i = MODE_PIXEL;
  logic [IN_PIX_W-1:0] pixel_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [MEAN_W-1:0] mean_value_o;
  logic frame_last_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  int errors, pending, sent_count, rx_stall;
  bit tx_burst, rx_burst;

  clipped_box_mean_filter_top uut (.*);

  cbmf_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .mode_i, .pixel_i,
    .out_valid_i(out_valid_o), .out_ready_i, .mean_value_i(mean_value_o),
    .frame_last_i(frame_last_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    int n;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_stall = 2;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if ($urandom_range(0, 40) == 0) rx_burst = ~rx_burst;
        n = rx_burst ? 0 : $urandom_range(0, 18);
      end else begin
        n = (rx_stall > 0) ? rx_stall - 1 : 0;
      end
      rx_stall = n;
      out_ready_i <= (n == 0);
    end
  end

  task automatic send_request(input logic m, input logic [IN_PIX_W-1:0] p);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    pixel_i <= p;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
    sent_count++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_regs(input int w, input int h, input int r);
    int order [3];
    order = '{0, 1, 2};
    order.shuffle();
    foreach (order[i]) begin
      cfg_valid_i <= 1'b1;
      case (order[i])
        0: begin cfg_index_i <= CFG_WIDTH;  cfg_data_i <= w[CFG_DATA_W-1:0]; end
        1: begin cfg_index_i <= CFG_HEIGHT; cfg_data_i <= h[CFG_DATA_W-1:0]; end
        default: begin cfg_index_i <= CFG_RADIUS; cfg_data_i <= r[CFG_DATA_W-1:0]; end
      endcase
      forever begin
        @(negedge clk_i);
        if (cfg_ready_o) break;
      end
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [IN_PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return IN_PIX_W'($urandom);
    endcase
  endfunction

  // Sends one frame; a nonzero stop_after abandons it after that many pixels.
  task automatic run_frame(input int w, input int h, input int r, input int stop_after);
    int total, tail, lag;
    w = (w == 0) ? 1 : (w > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : w);
    h = (h == 0) ? 1 : (h > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : h);
    r = (r > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : r;
    total = w * h;
    lag = r * w + r;
    tail = (lag < total) ? lag : total;
    tx_burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < total; i++) begin
      if (stop_after != 0 && i == stop_after) return;
      if ($urandom_range(0, 9) == 0) send_request(MODE_FLUSH, IN_PIX_W'($urandom));
      send_request(MODE_PIXEL, rand_pixel());
    end
    while (tail > 0) begin
      if ($urandom_range(0, 5) == 0) send_request(MODE_PIXEL, rand_pixel());
      else send_request(MODE_FLUSH, IN_PIX_W'($urandom));
      tail--;
    end
    if ($urandom_range(0, 3) == 0) send_request(MODE_FLUSH, '0);
  endtask

  initial begin
    int w, h, r;
    sent_count = 0;
    tx_burst = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_regs(4, 3, 1);
    send_request(MODE_FLUSH, '1);
    send_request(MODE_PIXEL, '0);
    send_request(MODE_PIXEL, '1);
    run_frame(4, 3, 1, 0);
    wait_idle();
    write_regs(0, 0, 0);
    run_frame(0, 0, 0, 0);
    run_frame(0, 0, 0, 0);
    wait_idle();
    write_regs(3, 2, 15);
    run_frame(3, 2, 15, 0);
    wait_idle();
    write_regs(1023, 1, 8);
    run_frame(1023, 1, 8, 60);
    wait_idle();
    write_regs(1, 200, 8);
    run_frame(1, 200, 8, 0);
    wait_idle();

    while (sent_count < 430) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      r = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      write_regs(w, h, r);
      repeat ($urandom_range(1, 3)) begin
        run_frame(w, h, r, 0);
      end
      if ($urandom_range(0, 3) == 0) run_frame(w, h, r, $urandom_range(1, w * h));
      wait_idle();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
